// ----- rtl/tkp_pkg.sv -----
// shared types, constants and register reset values for the touch key press detector
// no dependencies; imported by tkp_key and touch_key_press_detector_unit

package tkp_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int N_KEYS         = 7;
  localparam int NUM_REGS       = 8;
  localparam int REG_IDX_BITS   = 3;
  localparam int REG_BITS       = 16;
  localparam int CNT_BITS       = 5;

  localparam logic [REG_BITS-1:0] DOWN_REJECT = 16'h0230;
  localparam logic [CNT_BITS-1:0] TAP_WINDOW  = 5'd20;
  localparam logic [CNT_BITS-1:0] COUNTER_MAX = 5'd31;

  localparam logic REQ_CALIBRATE = 1'b0;

  // register indexes on the configuration port
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_THR_MIDDLE     = 3'd0,
    REG_THR_DOWN       = 3'd1,
    REG_THR_UP         = 3'd2,
    REG_THR_LEFT       = 3'd3,
    REG_THR_RIGHT      = 3'd4,
    REG_THR_DIAG_LEFT  = 3'd5,
    REG_THR_DIAG_RIGHT = 3'd6,
    REG_RELEASE_LEVEL  = 3'd7
  } tkp_reg_e;

  localparam int KEY_MID  = 0;
  localparam int KEY_DOWN = 1;

  localparam logic [REG_BITS-1:0] REG_RESET [NUM_REGS] = '{
    16'h01B0, 16'h0180, 16'h0180, 16'h0590, 16'h0590, 16'h0300, 16'h00A0, 16'd100
  };

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_CHECK  = 2'd1,
    ST_ACTION = 2'd2
  } tkp_state_e;

  typedef struct packed {
    logic        req_type;
    logic [15:0] count_middle;
    logic [15:0] count_down;
    logic [15:0] count_up;
    logic [15:0] count_left;
    logic [15:0] count_right;
    logic [15:0] count_diag_left;
    logic [15:0] count_diag_right;
  } tkp_in_t;

  typedef struct packed {
    logic        led_pulse;
    logic [6:0]  touch_mask;
    logic        any_touch;
    logic [1:0]  tap_phase;
    logic [15:0] middle_delta;
  } tkp_out_t;

endpackage

// ----- rtl/tkp_key.sv -----
// one key channel: baseline tracking, delta, touch flag and downward drift
// depends on tkp_pkg

module tkp_key import tkp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic [COUNT_BITS-1:0] baseline_i,
  input  logic [REG_BITS-1:0]   thr_i,
  output logic [COUNT_BITS-1:0] baseline_o,
  output logic [REG_BITS-1:0]   delta_o,
  output logic                  touch_o
);

  logic                  rises;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] tracked;
  logic [COUNT_BITS-1:0] delta;

  always_comb begin
    rises   = baseline_i < count_i;
    // extra bit keeps the sum from wrapping
    sum     = {1'b0, baseline_i} + {1'b0, count_i};
    tracked = rises ? sum[COUNT_BITS:1] : baseline_i;
    delta   = rises ? '0 : baseline_i - count_i;
    delta_o = REG_BITS'(delta);
    touch_o = !rises && (delta_o > thr_i);
    // drift down by one, saturating at zero
    baseline_o = (tracked != '0) ? tracked - COUNT_BITS'(1) : tracked;
  end

endmodule

// ----- rtl/touch_key_press_detector_unit.sv -----
// top level of the touch key press detector: config registers, baselines, press machine
// depends on tkp_pkg and tkp_key
//
//  channel  signals                              payload
//  in       in_valid_i / in_ready_o              in_data_i  (tkp_in_t)
//  out      out_valid_o / out_ready_i            out_data_o (tkp_out_t)
//  cfg      cfg_we_i, cfg_idx_i                  cfg_data_i (16 bits)
//
// one beat per cycle while the output is drained: a scan is worked out in the cycle it is
// accepted and its result sits in the output register in the next cycle
// in_ready_o is high while the output register is empty or being drained
// reset clears baselines, press machine and flags and loads the threshold defaults

module touch_key_press_detector_unit import tkp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  tkp_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output tkp_out_t                out_data_o,
  input  logic                    cfg_we_i,
  input  logic [REG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [REG_BITS-1:0]     cfg_data_i
);

  logic [REG_BITS-1:0]   regs_q     [NUM_REGS];
  logic [COUNT_BITS-1:0] baseline_q [N_KEYS];
  logic [COUNT_BITS-1:0] baseline_d [N_KEYS];
  logic [COUNT_BITS-1:0] drift      [N_KEYS];
  logic [COUNT_BITS-1:0] cnt        [N_KEYS];
  logic [REG_BITS-1:0]   delta      [N_KEYS];
  logic [N_KEYS-1:0]     mask;

  tkp_state_e            state_q, state_d;
  logic                  other_q, other_d;
  logic                  home_q, home_d;
  logic                  hvalid_q, hvalid_d;
  logic                  hinvalid_q, hinvalid_d;
  logic [CNT_BITS-1:0]   scan_q, scan_d, scan_inc;
  logic                  held;
  logic                  pulse;
  logic                  accept;
  logic                  is_cal;
  logic                  out_valid_q;
  tkp_out_t              out_q, out_d;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign is_cal      = in_data_i.req_type == REQ_CALIBRATE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cnt[0] = COUNT_BITS'(in_data_i.count_middle);
  assign cnt[1] = COUNT_BITS'(in_data_i.count_down);
  assign cnt[2] = COUNT_BITS'(in_data_i.count_up);
  assign cnt[3] = COUNT_BITS'(in_data_i.count_left);
  assign cnt[4] = COUNT_BITS'(in_data_i.count_right);
  assign cnt[5] = COUNT_BITS'(in_data_i.count_diag_left);
  assign cnt[6] = COUNT_BITS'(in_data_i.count_diag_right);

  for (genvar k = 0; k < N_KEYS; k++) begin : g_key
    tkp_key #(.COUNT_BITS(COUNT_BITS)) u_key (
      .count_i    (cnt[k]),
      .baseline_i (baseline_q[k]),
      .thr_i      (regs_q[k]),
      .baseline_o (drift[k]),
      .delta_o    (delta[k]),
      .touch_o    (mask[k])
    );
    assign baseline_d[k] = is_cal ? cnt[k] : drift[k];
  end

  always_comb begin
    held = 1'b0;
    for (int k = 0; k < N_KEYS; k++) begin
      if (delta[k] > regs_q[REG_RELEASE_LEVEL]) begin
        held = 1'b1;
      end
    end
  end

  assign scan_inc = (scan_q < COUNTER_MAX) ? scan_q + CNT_BITS'(1) : scan_q;

  // next state of the press machine and its flags
  always_comb begin
    state_d    = state_q;
    other_d    = other_q;
    home_d     = home_q;
    hvalid_d   = hvalid_q;
    hinvalid_d = hinvalid_q;
    scan_d     = scan_inc;
    unique case (state_q)
      ST_CHECK: begin
        if (other_q) begin
          if (!held) begin
            state_d = ST_ACTION;
          end
        end else if (home_q) begin
          if (delta[KEY_DOWN] > DOWN_REJECT || mask[6:2] != '0 ||
              delta[KEY_DOWN] > delta[KEY_MID]) begin
            hinvalid_d = 1'b1;
          end else if (delta[KEY_MID] > regs_q[REG_RELEASE_LEVEL]) begin
            hvalid_d = 1'b1;
          end else begin
            state_d = ST_ACTION;
          end
        end
      end
      ST_ACTION: begin
        hvalid_d   = 1'b0;
        other_d    = 1'b0;
        home_d     = 1'b0;
        hinvalid_d = 1'b0;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
        if (mask != '0) begin
          scan_d = '0;
          if (mask[6:1] != '0) begin
            other_d  = 1'b1;
            hvalid_d = 1'b0;
          end else begin
            other_d = 1'b0;
          end
          home_d  = mask[KEY_MID] && (mask[6:1] == '0);
          state_d = ST_CHECK;
        end
      end
    endcase
  end

  // machine outputs
  always_comb begin
    pulse = (state_q == ST_ACTION) && hvalid_q && !hinvalid_q && (scan_inc < TAP_WINDOW);
  end

  always_comb begin
    if (is_cal) begin
      out_d.led_pulse    = 1'b0;
      out_d.touch_mask   = '0;
      out_d.any_touch    = 1'b0;
      out_d.tap_phase    = state_q;
      out_d.middle_delta = '0;
    end else begin
      out_d.led_pulse    = pulse;
      out_d.touch_mask   = mask;
      out_d.any_touch    = mask != '0;
      out_d.tap_phase    = state_d;
      out_d.middle_delta = delta[KEY_MID];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        regs_q[r] <= REG_RESET[r];
      end
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N_KEYS; k++) begin
        baseline_q[k] <= '0;
      end
      state_q    <= ST_IDLE;
      other_q    <= 1'b0;
      home_q     <= 1'b0;
      hvalid_q   <= 1'b0;
      hinvalid_q <= 1'b0;
      scan_q     <= '0;
    end else if (accept) begin
      baseline_q <= baseline_d;
      // a calibrate beat leaves the machine and counter alone
      if (!is_cal) begin
        state_q    <= state_d;
        other_q    <= other_d;
        home_q     <= home_d;
        hvalid_q   <= hvalid_d;
        hinvalid_q <= hinvalid_d;
        scan_q     <= scan_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

endmodule
